FILE: src/vcwg_pkg.sv
// Shared types, register map and status codes for the velocity command watchdog gate.
// Used by every module of the block except vcwg_ram; depends on nothing.
package vcwg_pkg;

    localparam int JOINTS_DEFAULT = 6;
    localparam int FIELD_JOINTS   = 6;
    localparam int VEL_W          = 32;
    localparam int TIME_W         = 48;
    localparam int PERIOD_W       = 32;
    localparam int LIMIT_W        = 47;
    localparam int STATE_DEPTH    = 1;

    localparam int IN_DATA_W  = 272;
    localparam int IN_USER_W  = 4;
    localparam int OUT_DATA_W = 192;
    localparam int OUT_USER_W = 4;
    localparam int ADDR_W     = 4;

    localparam logic [1:0] OP_SUBMIT = 2'd0;
    localparam logic [1:0] OP_UPDATE = 2'd1;
    localparam logic [1:0] OP_RESET  = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    localparam logic [1:0] KIND_VALID     = 2'd0;
    localparam logic [1:0] KIND_SHAPE     = 2'd1;
    localparam logic [1:0] KIND_OVERRUN   = 2'd2;
    localparam logic [1:0] KIND_NONFINITE = 2'd3;

    localparam logic [2:0] ST_WAITING   = 3'd0;
    localparam logic [2:0] ST_ACTIVE    = 3'd1;
    localparam logic [2:0] ST_SHAPE     = 3'd2;
    localparam logic [2:0] ST_OVERRUN   = 3'd3;
    localparam logic [2:0] ST_NONFINITE = 3'd4;
    localparam logic [2:0] ST_VELOCITY  = 3'd5;
    localparam logic [2:0] ST_STALE     = 3'd6;
    localparam logic [2:0] ST_SLEW      = 3'd7;

    localparam logic [1:0] REG_MAX_VELOCITY  = 2'd0;
    localparam logic [1:0] REG_MAX_ACCEL     = 2'd1;
    localparam logic [1:0] REG_STALE_TIMEOUT = 2'd2;

    localparam logic [30:0] MAX_VELOCITY_RST  = 31'd65536;
    localparam logic [30:0] MAX_ACCEL_RST     = 31'd8;
    localparam logic [31:0] STALE_TIMEOUT_RST = 32'd100000;

    typedef struct packed {
        logic [30:0] max_velocity;
        logic [30:0] max_accel;
        logic [31:0] stale_timeout;
    } cfg_t;

    typedef struct packed {
        logic [1:0]                             opcode;
        logic [1:0]                             event_kind;
        logic [TIME_W-1:0]                      time_stamp;
        logic [PERIOD_W-1:0]                    period_us;
        logic [FIELD_JOINTS-1:0][VEL_W-1:0]     velocity;
    } item_t;

    typedef struct packed {
        logic [TIME_W-1:0] last_receive_time;
        logic              have_command;
        logic              fault_latched;
        logic [2:0]        current_status;
    } gate_state_t;

endpackage

FILE: src/vcwg_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
module vcwg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1
) (
    input  logic                                         clk,
    input  logic                                         wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]   wr_addr,
    input  logic [WIDTH-1:0]                             wr_data,
    input  logic                                         rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]   rd_addr,
    output logic [WIDTH-1:0]                             rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: src/vcwg_regs.sv
// APB configuration registers: velocity limit, acceleration limit, stale timeout.
// Depends on vcwg_pkg.
module vcwg_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [vcwg_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output vcwg_pkg::cfg_t              cfg
);

    vcwg_pkg::cfg_t cfg_reg;
    vcwg_pkg::cfg_t cfg_next;
    logic           wr_stb;

    assign pready = 1'b1;
    assign wr_stb = psel & penable & pwrite;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_stb)
        begin
            unique case (paddr[3:2])
                vcwg_pkg::REG_MAX_VELOCITY:  cfg_next.max_velocity  = pwdata[30:0];
                vcwg_pkg::REG_MAX_ACCEL:     cfg_next.max_accel     = pwdata[30:0];
                vcwg_pkg::REG_STALE_TIMEOUT: cfg_next.stale_timeout = pwdata;
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            vcwg_pkg::REG_MAX_VELOCITY:  prdata = {1'b0, cfg_reg.max_velocity};
            vcwg_pkg::REG_MAX_ACCEL:     prdata = {1'b0, cfg_reg.max_accel};
            vcwg_pkg::REG_STALE_TIMEOUT: prdata = cfg_reg.stale_timeout;
            default:                     prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_velocity  <= vcwg_pkg::MAX_VELOCITY_RST;
            cfg_reg.max_accel     <= vcwg_pkg::MAX_ACCEL_RST;
            cfg_reg.stale_timeout <= vcwg_pkg::STALE_TIMEOUT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: src/vcwg_eval.sv
// Decision logic of the gate: checks one item against the stored command and state
// and forms the new memory word, new state and the active flag. Depends on vcwg_pkg.
module vcwg_eval #(
    parameter int JOINTS = vcwg_pkg::JOINTS_DEFAULT
) (
    input  vcwg_pkg::item_t                            item,
    input  logic [vcwg_pkg::LIMIT_W-1:0]               limit,
    input  logic [JOINTS-1:0][vcwg_pkg::VEL_W-1:0]     pend,
    input  logic [JOINTS-1:0][vcwg_pkg::VEL_W-1:0]     last,
    input  vcwg_pkg::gate_state_t                      st,
    input  vcwg_pkg::cfg_t                             cfg,
    output logic [JOINTS-1:0][vcwg_pkg::VEL_W-1:0]     pend_next,
    output logic [JOINTS-1:0][vcwg_pkg::VEL_W-1:0]     last_next,
    output vcwg_pkg::gate_state_t                      st_next,
    output logic                                       active
);

    logic        vel_over;
    logic        slew_over;
    logic        backwards;
    logic        stale;
    logic [47:0] age;

    // per-joint magnitude and slew checks, all joints side by side
    always_comb
    begin
        logic [32:0] v_ext;
        logic [32:0] v_mag;
        logic [33:0] d;
        logic [33:0] d_mag;
        vel_over  = 1'b0;
        slew_over = 1'b0;
        for (int j = 0; j < JOINTS; j++)
        begin
            v_ext = {item.velocity[j][31], item.velocity[j]};
            v_mag = v_ext[32] ? (33'd0 - v_ext) : v_ext;
            if (v_mag > {2'b00, cfg.max_velocity})
            begin
                vel_over = 1'b1;
            end
            // difference of two 32-bit values, held in 34 bits with sign
            d     = {{2{pend[j][31]}}, pend[j]} - {{2{last[j][31]}}, last[j]};
            d_mag = d[33] ? (34'd0 - d) : d;
            if ({13'd0, d_mag} > limit)
            begin
                slew_over = 1'b1;
            end
        end
    end

    assign backwards = item.time_stamp < st.last_receive_time;
    assign age       = item.time_stamp - st.last_receive_time;
    assign stale     = age > {16'd0, cfg.stale_timeout};

    always_comb
    begin
        logic       trip;
        logic [2:0] trip_code;
        pend_next = pend;
        last_next = last;
        st_next   = st;
        active    = 1'b0;
        trip      = 1'b0;
        trip_code = st.current_status;
        unique case (item.opcode)
            vcwg_pkg::OP_SUBMIT:
            begin
                if (!st.fault_latched)
                begin
                    priority if (item.event_kind == vcwg_pkg::KIND_SHAPE)
                    begin
                        trip      = 1'b1;
                        trip_code = vcwg_pkg::ST_SHAPE;
                    end
                    else if (item.event_kind == vcwg_pkg::KIND_OVERRUN)
                    begin
                        trip      = 1'b1;
                        trip_code = vcwg_pkg::ST_OVERRUN;
                    end
                    else if (item.event_kind == vcwg_pkg::KIND_NONFINITE)
                    begin
                        trip      = 1'b1;
                        trip_code = vcwg_pkg::ST_NONFINITE;
                    end
                    else if (vel_over)
                    begin
                        trip      = 1'b1;
                        trip_code = vcwg_pkg::ST_VELOCITY;
                    end
                    else
                    begin
                        for (int j = 0; j < JOINTS; j++)
                        begin
                            pend_next[j] = item.velocity[j];
                        end
                        st_next.last_receive_time = item.time_stamp;
                        st_next.have_command      = 1'b1;
                    end
                end
            end
            vcwg_pkg::OP_UPDATE:
            begin
                if (!st.fault_latched)
                begin
                    priority if (item.period_us == '0)
                    begin
                        trip      = 1'b1;
                        trip_code = vcwg_pkg::ST_NONFINITE;
                    end
                    else if (!st.have_command)
                    begin
                        st_next.current_status = vcwg_pkg::ST_WAITING;
                    end
                    else if (backwards)
                    begin
                        trip      = 1'b1;
                        trip_code = vcwg_pkg::ST_NONFINITE;
                    end
                    else if (stale)
                    begin
                        trip      = 1'b1;
                        trip_code = vcwg_pkg::ST_STALE;
                    end
                    else if (slew_over)
                    begin
                        trip      = 1'b1;
                        trip_code = vcwg_pkg::ST_SLEW;
                    end
                    else
                    begin
                        last_next              = pend;
                        st_next.current_status = vcwg_pkg::ST_ACTIVE;
                        active                 = 1'b1;
                    end
                end
            end
            vcwg_pkg::OP_RESET:
            begin
                pend_next                 = '0;
                last_next                 = '0;
                st_next.last_receive_time = item.time_stamp;
                st_next.have_command      = 1'b0;
                st_next.fault_latched     = 1'b0;
                st_next.current_status    = vcwg_pkg::ST_WAITING;
            end
            default:
            begin
                st_next = st;
            end
        endcase
        // any latch drops both stored commands
        if (trip)
        begin
            pend_next              = '0;
            last_next              = '0;
            st_next.fault_latched  = 1'b1;
            st_next.current_status = trip_code;
        end
    end

endmodule

FILE: src/velocity_command_watchdog_gate.sv
// Top level of the velocity command watchdog gate: stream ports, APB registers,
// command memory with forwarding, evaluation stage and output register.
// Depends on vcwg_pkg, vcwg_ram, vcwg_regs and vcwg_eval.
//
//   channel   direction  handshake            payload
//   s_        in         s_tvalid / s_tready  command, update tick or reset item
//   m_        out        m_tvalid / m_tready  status, latch flag, output velocities
//   APB       in         psel, penable        max_velocity, max_accel, stale_timeout
//
// The accept cycle issues the command-memory read and the slew-limit multiply; the
// evaluation stage then evaluates and, when it advances, writes the memory back.
// A new item is accepted every cycle while no result stalls; one result per item.
// A write in the evaluation cycle is forwarded to the item read at the same edge.
// Reset clears all control state; the memory reads as zero until first written.
// A stalled result beat holds the evaluation stage, which then holds s_tready low.
module velocity_command_watchdog_gate #(
    parameter int JOINTS = vcwg_pkg::JOINTS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // time_stamp[47:0], period_us[79:48], velocity_0..velocity_5 at 32 bits each from 80
    input  logic [vcwg_pkg::IN_DATA_W-1:0]  s_tdata,
    // opcode[1:0], event_kind[3:2]
    input  logic [vcwg_pkg::IN_USER_W-1:0]  s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // out_velocity_0..out_velocity_5 at 32 bits each from bit 0
    output logic [vcwg_pkg::OUT_DATA_W-1:0] m_tdata,
    // gate_status[2:0], is_latched[3]
    output logic [vcwg_pkg::OUT_USER_W-1:0] m_tuser,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [vcwg_pkg::ADDR_W-1:0]     paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    localparam int WORD_W = 2 * JOINTS * vcwg_pkg::VEL_W;
    localparam int MEM_AW = vcwg_pkg::STATE_DEPTH > 1 ? $clog2(vcwg_pkg::STATE_DEPTH) : 1;

    vcwg_pkg::cfg_t        cfg;
    vcwg_pkg::item_t       in_item;
    vcwg_pkg::item_t       s1_item_reg;
    vcwg_pkg::gate_state_t st_reg;
    vcwg_pkg::gate_state_t st_next;

    logic                                 s_accept;
    logic                                 s1_adv;
    logic                                 s1_valid_reg;
    logic                                 s1_valid_next;
    logic [vcwg_pkg::LIMIT_W-1:0]         s1_limit_reg;
    logic [62:0]                          accel_prod;

    logic [WORD_W-1:0]                    ram_rd_data;
    logic [WORD_W-1:0]                    ram_wr_data;
    logic [WORD_W-1:0]                    word_cur;
    logic [WORD_W-1:0]                    fwd_data_reg;
    logic                                 fwd_reg;
    logic                                 rd_zero_reg;
    logic                                 written_reg;

    logic [JOINTS-1:0][vcwg_pkg::VEL_W-1:0] pend;
    logic [JOINTS-1:0][vcwg_pkg::VEL_W-1:0] last;
    logic [JOINTS-1:0][vcwg_pkg::VEL_W-1:0] pend_next;
    logic [JOINTS-1:0][vcwg_pkg::VEL_W-1:0] last_next;
    logic                                 active;

    logic                                 m_valid_reg;
    logic                                 m_valid_next;
    logic [vcwg_pkg::OUT_DATA_W-1:0]      m_data_reg;
    logic [vcwg_pkg::OUT_DATA_W-1:0]      m_data_next;
    logic [vcwg_pkg::OUT_USER_W-1:0]      m_user_reg;

    vcwg_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // unpack the input beat
    always_comb
    begin
        in_item.opcode     = s_tuser[1:0];
        in_item.event_kind = s_tuser[3:2];
        in_item.time_stamp = s_tdata[47:0];
        in_item.period_us  = s_tdata[79:48];
        for (int j = 0; j < vcwg_pkg::FIELD_JOINTS; j++)
        begin
            in_item.velocity[j] = s_tdata[80 + 32 * j +: 32];
        end
    end

    assign s1_adv   = s1_valid_reg & (~m_valid_reg | m_tready);
    assign s_tready = ~s1_valid_reg | s1_adv;
    assign s_accept = s_tvalid & s_tready;

    assign accel_prod    = {1'b0, cfg.max_accel} * {31'd0, in_item.period_us};
    assign s1_valid_next = s_accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);

    vcwg_ram #(
        .WIDTH (WORD_W),
        .DEPTH (vcwg_pkg::STATE_DEPTH)
    ) u_cmd_ram (
        .clk     (clk),
        .wr_en   (s1_adv),
        .wr_addr (MEM_AW'(0)),
        .wr_data (ram_wr_data),
        .rd_en   (s_accept),
        .rd_addr (MEM_AW'(0)),
        .rd_data (ram_rd_data)
    );

    // forwarded write wins, then the never-written entry reads as zero
    always_comb
    begin
        priority if (fwd_reg)
        begin
            word_cur = fwd_data_reg;
        end
        else if (rd_zero_reg)
        begin
            word_cur = '0;
        end
        else
        begin
            word_cur = ram_rd_data;
        end
    end

    assign pend        = word_cur[JOINTS * vcwg_pkg::VEL_W - 1 : 0];
    assign last        = word_cur[WORD_W - 1 : JOINTS * vcwg_pkg::VEL_W];
    assign ram_wr_data = {last_next, pend_next};

    vcwg_eval #(
        .JOINTS (JOINTS)
    ) u_eval (
        .item      (s1_item_reg),
        .limit     (s1_limit_reg),
        .pend      (pend),
        .last      (last),
        .st        (st_reg),
        .cfg       (cfg),
        .pend_next (pend_next),
        .last_next (last_next),
        .st_next   (st_next),
        .active    (active)
    );

    always_comb
    begin
        m_data_next = '0;
        for (int j = 0; j < JOINTS; j++)
        begin
            if (active)
            begin
                m_data_next[32 * j +: 32] = pend[j];
            end
        end
    end

    assign m_valid_next = s1_adv ? 1'b1 : ((m_valid_reg & m_tready) ? 1'b0 : m_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            fwd_reg      <= 1'b0;
            rd_zero_reg  <= 1'b1;
            written_reg  <= 1'b0;
            st_reg       <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
            if (s_accept)
            begin
                fwd_reg     <= s1_adv;
                rd_zero_reg <= ~written_reg;
            end
            if (s1_adv)
            begin
                written_reg <= 1'b1;
                st_reg      <= st_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_item_reg  <= in_item;
            s1_limit_reg <= accel_prod[62:16];
            fwd_data_reg <= ram_wr_data;
        end
        if (s1_adv)
        begin
            m_data_reg <= m_data_next;
            m_user_reg <= {st_next.fault_latched, st_next.current_status};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // a latched gate passes no velocity
    a_latched_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[3]) |-> (m_tdata == '0))
        else $error("velocity passed while latched");

    // latched beats carry a fault code, open beats carry waiting or active
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser[3] == (m_tuser[2:0] >= vcwg_pkg::ST_SHAPE)))
        else $error("status code disagrees with latch flag");

    // input stalls only when the evaluation stage is blocked by a waiting result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (s1_valid_reg && m_tvalid && !m_tready))
        else $error("input stalled without a blocked result");

    // a finished evaluation always lands in the output register
    a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> m_tvalid)
        else $error("evaluated item produced no result beat");

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for velocity_command_watchdog_gate: stream driver and monitor,
// APB register writes with read-back, and a per-item predictor of the gate.
// Depends on vcwg_pkg and the RTL of the block; needs no other file.
module tb_top;

    localparam int CYCLE_LIMIT = 300000;
    localparam int NJ          = vcwg_pkg::FIELD_JOINTS;
    localparam int VW          = vcwg_pkg::VEL_W;
    localparam int TW          = vcwg_pkg::TIME_W;

    typedef struct packed {
        vcwg_pkg::item_t body;
        logic            hold;
    } beat_t;

    typedef struct packed {
        logic [2:0]              status;
        logic                    latched;
        logic [NJ-1:0][VW-1:0]   vel;
    } gate_result_t;

    logic                                 clk = 1'b0;
    logic                                 rst_n = 1'b0;
    logic                                 s_tvalid = 1'b0;
    logic                                 s_tready;
    logic [vcwg_pkg::IN_DATA_W-1:0]       s_tdata = '0;
    logic [vcwg_pkg::IN_USER_W-1:0]       s_tuser = '0;
    logic                                 m_tvalid;
    logic                                 m_tready = 1'b0;
    logic [vcwg_pkg::OUT_DATA_W-1:0]      m_tdata;
    logic [vcwg_pkg::OUT_USER_W-1:0]      m_tuser;
    logic                                 psel = 1'b0;
    logic                                 penable = 1'b0;
    logic                                 pwrite = 1'b0;
    logic [vcwg_pkg::ADDR_W-1:0]          paddr = '0;
    logic [31:0]                          pwdata = '0;
    logic [31:0]                          prdata;
    logic                                 pready;

    velocity_command_watchdog_gate u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #4 clk = ~clk;

    // Gate predictor state and register copies
    logic [30:0]            cfg_vel = vcwg_pkg::MAX_VELOCITY_RST;
    logic [30:0]            cfg_acc = vcwg_pkg::MAX_ACCEL_RST;
    logic [31:0]            cfg_tmo = vcwg_pkg::STALE_TIMEOUT_RST;
    logic [NJ-1:0][VW-1:0]  pend_v = '0;
    logic [NJ-1:0][VW-1:0]  last_v = '0;
    logic [TW-1:0]          rx_time = '0;
    logic                   have_cmd = 1'b0;
    logic                   latched_m = 1'b0;
    logic [2:0]             status_m = vcwg_pkg::ST_WAITING;

    beat_t        stim_q[$];
    gate_result_t exp_q[$];
    beat_t        cur_beat;
    gate_result_t want_r;
    int           pushed_cnt = 0;
    int           accept_cnt = 0;
    int           err_cnt = 0;
    int           src_gap = 0;
    int           dst_stall = 0;
    int           cyc = 0;
    logic         quiet = 1'b0;

    // Stimulus generator view of the gate
    logic [TW-1:0] g_time = '0;
    longint        g_base[NJ];
    logic          g_tripped = 1'b0;

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        err_cnt++;
        $display("mismatch: %s got 0x%0h expected 0x%0h", what, got, want);
    endtask

    function automatic longint unsigned vmag(input logic [VW-1:0] v);
        longint s;
        s = longint'($signed(v));
        return (s < 0) ? -s : s;
    endfunction

    task automatic gate_trip(input logic [2:0] st);
        pend_v    = '0;
        last_v    = '0;
        latched_m = 1'b1;
        status_m  = st;
    endtask

    task automatic gate_predict(input vcwg_pkg::item_t it);
        gate_result_t     r;
        logic             active;
        logic             bad;
        longint unsigned  lim;
        longint           d;
        active = 1'b0;
        unique case (it.opcode)
            vcwg_pkg::OP_SUBMIT:
            begin
                if (!latched_m)
                begin
                    if (it.event_kind == vcwg_pkg::KIND_SHAPE)
                        gate_trip(vcwg_pkg::ST_SHAPE);
                    else if (it.event_kind == vcwg_pkg::KIND_OVERRUN)
                        gate_trip(vcwg_pkg::ST_OVERRUN);
                    else if (it.event_kind == vcwg_pkg::KIND_NONFINITE)
                        gate_trip(vcwg_pkg::ST_NONFINITE);
                    else
                    begin
                        bad = 1'b0;
                        for (int j = 0; j < NJ; j++)
                            if (vmag(it.velocity[j]) > 64'(cfg_vel))
                                bad = 1'b1;
                        if (bad)
                            gate_trip(vcwg_pkg::ST_VELOCITY);
                        else
                        begin
                            pend_v   = it.velocity;
                            rx_time  = it.time_stamp;
                            have_cmd = 1'b1;
                        end
                    end
                end
            end
            vcwg_pkg::OP_UPDATE:
            begin
                if (!latched_m)
                begin
                    if (it.period_us == '0)
                        gate_trip(vcwg_pkg::ST_NONFINITE);
                    else if (!have_cmd)
                        status_m = vcwg_pkg::ST_WAITING;
                    else if (it.time_stamp < rx_time)
                        gate_trip(vcwg_pkg::ST_NONFINITE);
                    else if ((it.time_stamp - rx_time) > {16'b0, cfg_tmo})
                        gate_trip(vcwg_pkg::ST_STALE);
                    else
                    begin
                        lim = (64'(cfg_acc) * 64'(it.period_us)) >> 16;
                        bad = 1'b0;
                        for (int j = 0; j < NJ; j++)
                        begin
                            d = longint'($signed(pend_v[j])) - longint'($signed(last_v[j]));
                            if (d < 0)
                                d = -d;
                            if (d > longint'(lim))
                                bad = 1'b1;
                        end
                        if (bad)
                            gate_trip(vcwg_pkg::ST_SLEW);
                        else
                        begin
                            last_v   = pend_v;
                            status_m = vcwg_pkg::ST_ACTIVE;
                            active   = 1'b1;
                        end
                    end
                end
            end
            vcwg_pkg::OP_RESET:
            begin
                pend_v    = '0;
                last_v    = '0;
                rx_time   = it.time_stamp;
                have_cmd  = 1'b0;
                latched_m = 1'b0;
                status_m  = vcwg_pkg::ST_WAITING;
            end
            default: ;
        endcase
        r.status  = status_m;
        r.latched = latched_m;
        r.vel     = active ? last_v : '0;
        exp_q.push_back(r);
    endtask

    // Source side: present queued beats, insert random gaps, honor hold requests
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            src_gap  = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                gate_predict(cur_beat.body);
                accept_cnt++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (stim_q.size() > 0 && !(stim_q[0].hold && exp_q.size() > 0))
                begin
                    cur_beat = stim_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {cur_beat.body.velocity, cur_beat.body.period_us,
                                 cur_beat.body.time_stamp};
                    s_tuser  <= {cur_beat.body.event_kind, cur_beat.body.opcode};
                    if (!quiet && $urandom_range(0, 4) == 0)
                        src_gap = int'($urandom_range(1, 15));
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Sink side: random backpressure, compare every result beat
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            dst_stall = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (exp_q.size() == 0)
                    report_mismatch("result beat with no expectation", 64'(m_tuser), 64'd0);
                else
                begin
                    want_r = exp_q.pop_front();
                    if (m_tuser[2:0] !== want_r.status)
                        report_mismatch("gate_status", 64'(m_tuser[2:0]),
                                        64'(want_r.status));
                    if (m_tuser[3] !== want_r.latched)
                        report_mismatch("is_latched", 64'(m_tuser[3]), 64'(want_r.latched));
                    for (int j = 0; j < NJ; j++)
                        if (m_tdata[32*j +: 32] !== want_r.vel[j])
                            report_mismatch($sformatf("out_velocity_%0d", j),
                                            64'(m_tdata[32*j +: 32]), 64'(want_r.vel[j]));
                end
            end
            if (dst_stall > 0)
            begin
                dst_stall--;
                m_tready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 11) == 0)
            begin
                dst_stall = int'($urandom_range(0, 14));
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cyc++;
        if (cyc > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cyc);
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic queue_beat(input vcwg_pkg::item_t it, input logic h);
        beat_t b;
        b.body = it;
        b.hold = h;
        stim_q.push_back(b);
        pushed_cnt++;
    endtask

    function automatic vcwg_pkg::item_t mk_item(input logic [1:0] op, input logic [1:0] kind,
                                                input logic [47:0] stamp,
                                                input logic [31:0] per,
                                                input logic [NJ-1:0][VW-1:0] vel);
        vcwg_pkg::item_t it;
        it.opcode     = op;
        it.event_kind = kind;
        it.time_stamp = stamp;
        it.period_us  = per;
        it.velocity   = vel;
        return it;
    endfunction

    function automatic logic [NJ-1:0][VW-1:0] rand_vel();
        logic [NJ-1:0][VW-1:0] v;
        for (int j = 0; j < NJ; j++)
            v[j] = $urandom;
        return v;
    endfunction

    function automatic logic [47:0] rand_stamp();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[47:0];
    endfunction

    task automatic wait_drained();
        while (accept_cnt != pushed_cnt || exp_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write one register, then read it back
    task automatic apb_access(input logic [1:0] idx, input logic [31:0] val);
        logic [31:0] want;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        unique case (idx)
            vcwg_pkg::REG_MAX_VELOCITY: cfg_vel = val[30:0];
            vcwg_pkg::REG_MAX_ACCEL:    cfg_acc = val[30:0];
            default:                    cfg_tmo = val;
        endcase
        want = (idx == vcwg_pkg::REG_STALE_TIMEOUT) ? val : {1'b0, val[30:0]};
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== want)
            report_mismatch($sformatf("register %0d read-back", idx), 64'(prdata),
                            64'(want));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_config(input logic [31:0] vel, input logic [31:0] acc,
                              input logic [31:0] tmo);
        wait_drained();
        apb_access(vcwg_pkg::REG_MAX_VELOCITY, vel);
        apb_access(vcwg_pkg::REG_MAX_ACCEL, acc);
        apb_access(vcwg_pkg::REG_STALE_TIMEOUT, tmo);
    endtask

    task automatic gen_random(input int count);
        vcwg_pkg::item_t  it;
        int               pick;
        int               sel;
        int               jj;
        logic             over;
        longint unsigned  dlim;
        longint unsigned  want;
        longint unsigned  per;
        longint unsigned  m;
        longint           v;
        logic [47:0]      age;
        for (int k = 0; k < count; k++)
        begin
            it = '0;
            pick = int'($urandom_range(0, 99));
            // steer back to a clean state after a deliberate fault
            if (g_tripped && $urandom_range(0, 3) != 0)
                pick = 100;
            dlim = (cfg_vel < 31'd20000) ? 64'(cfg_vel) : 64'd20000;
            if (pick < 40)
            begin
                it.opcode     = vcwg_pkg::OP_SUBMIT;
                it.event_kind = vcwg_pkg::KIND_VALID;
                it.time_stamp = g_time + 48'($urandom_range(0, 200));
                for (int j = 0; j < NJ; j++)
                begin
                    v = g_base[j] + longint'($urandom_range(0, 32'(2 * dlim))) - longint'(dlim);
                    if (v > longint'(cfg_vel))
                        v = longint'(cfg_vel);
                    if (v < -longint'(cfg_vel))
                        v = -longint'(cfg_vel);
                    it.velocity[j] = v[31:0];
                end
                over = ($urandom_range(0, 19) == 0);
                if (over)
                begin
                    jj = int'($urandom_range(0, NJ - 1));
                    m  = 64'(cfg_vel) + 64'd1 + 64'($urandom_range(0, 1000));
                    if (m > 64'h8000_0000)
                        m = 64'h8000_0000;
                    v = $urandom_range(0, 1) ? -longint'(m) : longint'(m);
                    if (v > 2147483647)
                        v = -v;
                    it.velocity[jj] = v[31:0];
                    g_tripped = 1'b1;
                end
                else
                begin
                    g_time = it.time_stamp;
                    for (int j = 0; j < NJ; j++)
                        g_base[j] = longint'($signed(it.velocity[j]));
                end
            end
            else if (pick < 75)
            begin
                it.opcode     = vcwg_pkg::OP_UPDATE;
                it.event_kind = 2'($urandom_range(0, 3));
                it.velocity   = rand_vel();
                // period just wide enough for the expected slew, usually
                want = 4 * dlim + 4;
                per  = ((want << 16) + 64'(cfg_acc) - 1) / 64'(cfg_acc);
                per  = per + 64'($urandom_range(0, 15));
                if (per > 64'hFFFF_FFFF)
                    per = 64'hFFFF_FFFF;
                sel = int'($urandom_range(0, 9));
                if (sel == 0)
                begin
                    per = 0;
                    g_tripped = 1'b1;
                end
                else if (sel < 3)
                begin
                    per = 64'($urandom);
                    if (per == 0)
                        per = 1;
                end
                it.period_us = per[31:0];
                sel = int'($urandom_range(0, 99));
                if (sel < 80)
                    age = 48'($urandom_range(0, cfg_tmo));
                else if (sel < 88)
                    age = 48'(cfg_tmo);
                else if (sel < 95)
                begin
                    age = 48'(cfg_tmo) + 48'd1 + 48'($urandom_range(0, 50));
                    g_tripped = 1'b1;
                end
                else
                begin
                    age = -48'($urandom_range(1, 100));
                    g_tripped = 1'b1;
                end
                it.time_stamp = g_time + age;
            end
            else if (pick < 85 || pick == 100)
            begin
                it.opcode     = vcwg_pkg::OP_RESET;
                it.event_kind = 2'($urandom_range(0, 3));
                it.period_us  = $urandom;
                sel = int'($urandom_range(0, 9));
                if (sel < 6)
                    it.time_stamp = g_time + 48'($urandom_range(0, 500));
                else if (sel < 8)
                    it.time_stamp = rand_stamp();
                else
                    it.time_stamp = '0;
                g_time    = it.time_stamp;
                g_tripped = 1'b0;
                for (int j = 0; j < NJ; j++)
                    g_base[j] = 0;
            end
            else if (pick < 90)
            begin
                it.opcode     = vcwg_pkg::OP_SUBMIT;
                it.event_kind = 2'($urandom_range(1, 3));
                it.time_stamp = g_time + 48'($urandom_range(0, 100));
                it.velocity   = rand_vel();
                g_tripped     = 1'b1;
            end
            else if (pick < 95)
            begin
                it = mk_item(vcwg_pkg::OP_NONE, 2'($urandom_range(0, 3)), rand_stamp(),
                             $urandom, rand_vel());
            end
            else
            begin
                it = mk_item(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), rand_stamp(),
                             $urandom, rand_vel());
                g_tripped = 1'b1;
            end
            queue_beat(it, $urandom_range(0, 49) == 0);
        end
    endtask

    initial
    begin
        logic [NJ-1:0][VW-1:0] vv;
        for (int j = 0; j < NJ; j++)
            g_base[j] = 0;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under reset register values
        queue_beat(mk_item(vcwg_pkg::OP_UPDATE, vcwg_pkg::KIND_VALID, 48'd0, 32'd10, '0),
                   1'b0);
        queue_beat(mk_item(vcwg_pkg::OP_UPDATE, vcwg_pkg::KIND_VALID, 48'd5, 32'd0, '0),
                   1'b0);
        queue_beat(mk_item(vcwg_pkg::OP_SUBMIT, vcwg_pkg::KIND_VALID, 48'd6, 32'd0,
                           {NJ{32'd5}}), 1'b0);
        queue_beat(mk_item(vcwg_pkg::OP_UPDATE, vcwg_pkg::KIND_VALID, 48'd7, 32'd100, '0),
                   1'b0);
        queue_beat(mk_item(vcwg_pkg::OP_NONE, vcwg_pkg::KIND_SHAPE, 48'd8, 32'd9, rand_vel()),
                   1'b0);
        queue_beat(mk_item(vcwg_pkg::OP_RESET, vcwg_pkg::KIND_VALID, 48'd1000, 32'd0, '0),
                   1'b0);
        // magnitudes exactly at the limit pass, slew exactly at the limit passes
        vv = {32'd65536, 32'd0, -32'sd65536, 32'd65536, -32'sd65536, 32'd65536};
        queue_beat(mk_item(vcwg_pkg::OP_SUBMIT, vcwg_pkg::KIND_VALID, 48'd1000, 32'd0, vv),
                   1'b0);
        queue_beat(mk_item(vcwg_pkg::OP_UPDATE, vcwg_pkg::KIND_VALID, 48'd1000,
                           32'd536870912, '0), 1'b0);
        queue_beat(mk_item(vcwg_pkg::OP_UPDATE, vcwg_pkg::KIND_VALID, 48'd101000, 32'd1, '0),
                   1'b0);
        queue_beat(mk_item(vcwg_pkg::OP_UPDATE, vcwg_pkg::KIND_VALID, 48'd101001, 32'd1, '0),
                   1'b0);
        queue_beat(mk_item(vcwg_pkg::OP_RESET, vcwg_pkg::KIND_VALID, 48'd2000, 32'd0, '0),
                   1'b0);
        vv = '0;
        vv[3] = 32'd65537;
        queue_beat(mk_item(vcwg_pkg::OP_SUBMIT, vcwg_pkg::KIND_VALID, 48'd2000, 32'd0, vv),
                   1'b0);
        queue_beat(mk_item(vcwg_pkg::OP_RESET, vcwg_pkg::KIND_VALID, 48'd0, 32'd0, '0), 1'b0);
        queue_beat(mk_item(vcwg_pkg::OP_SUBMIT, vcwg_pkg::KIND_SHAPE, 48'd1, 32'd0, '0), 1'b0);
        queue_beat(mk_item(vcwg_pkg::OP_RESET, vcwg_pkg::KIND_VALID, 48'd0, 32'd0, '0), 1'b0);
        queue_beat(mk_item(vcwg_pkg::OP_SUBMIT, vcwg_pkg::KIND_OVERRUN, 48'd1, 32'd0, '0),
                   1'b0);
        queue_beat(mk_item(vcwg_pkg::OP_RESET, vcwg_pkg::KIND_VALID, 48'd0, 32'd0, '0), 1'b0);
        queue_beat(mk_item(vcwg_pkg::OP_SUBMIT, vcwg_pkg::KIND_NONFINITE, 48'd1, 32'd0, '0),
                   1'b0);
        // hold this beat until the gate has answered everything before it
        queue_beat(mk_item(vcwg_pkg::OP_RESET, vcwg_pkg::KIND_VALID, 48'd50, 32'd0, '0), 1'b1);
        queue_beat(mk_item(vcwg_pkg::OP_SUBMIT, vcwg_pkg::KIND_VALID, 48'd60, 32'd0,
                           {NJ{32'd100}}), 1'b0);
        queue_beat(mk_item(vcwg_pkg::OP_UPDATE, vcwg_pkg::KIND_VALID, 48'd59, 32'd1000000,
                           '0), 1'b0);
        queue_beat(mk_item(vcwg_pkg::OP_RESET, vcwg_pkg::KIND_VALID, 48'd0, 32'd0, '0), 1'b0);
        queue_beat(mk_item(vcwg_pkg::OP_SUBMIT, vcwg_pkg::KIND_VALID, 48'd0, 32'd0,
                           {NJ{32'd100}}), 1'b0);
        queue_beat(mk_item(vcwg_pkg::OP_UPDATE, vcwg_pkg::KIND_VALID, 48'd0, 32'd1, '0), 1'b0);
        queue_beat(mk_item(vcwg_pkg::OP_RESET, vcwg_pkg::KIND_VALID, 48'hFFFF_FFFF_FFFF,
                           32'd0, '0), 1'b0);
        vv = '0;
        vv[0] = 32'h8000_0000;
        queue_beat(mk_item(vcwg_pkg::OP_SUBMIT, vcwg_pkg::KIND_VALID, 48'hFFFF_FFFF_FFFF,
                           32'd0, vv), 1'b0);
        queue_beat(mk_item(vcwg_pkg::OP_RESET, vcwg_pkg::KIND_VALID, 48'd0, 32'd0, '0), 1'b0);
        vv = '0;
        vv[5] = 32'h7FFF_FFFF;
        queue_beat(mk_item(vcwg_pkg::OP_SUBMIT, vcwg_pkg::KIND_VALID, 48'd0, 32'd0, vv), 1'b0);
        queue_beat(mk_item(vcwg_pkg::OP_RESET, vcwg_pkg::KIND_VALID, 48'd0, 32'd0, '0), 1'b0);
        queue_beat(mk_item(vcwg_pkg::OP_SUBMIT, vcwg_pkg::KIND_VALID, 48'hFFFF_FFFF_FFFF,
                           32'd0, '0), 1'b0);
        queue_beat(mk_item(vcwg_pkg::OP_UPDATE, vcwg_pkg::KIND_VALID, 48'hFFFF_FFFF_FFFF,
                           32'hFFFF_FFFF, '0), 1'b0);
        queue_beat(mk_item(vcwg_pkg::OP_RESET, vcwg_pkg::KIND_VALID, 48'd0, 32'd0, '0), 1'b0);

        // Random phases across register settings, extremes first
        set_config(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        g_time = '0;
        gen_random(130);
        set_config(32'd1, 32'd1, 32'd1);
        gen_random(90);
        set_config(32'd100000, 32'd4096, 32'd50000);
        gen_random(150);
        set_config($urandom_range(1, 32'h7FFF_FFFF), $urandom_range(1, 65536),
                   $urandom_range(1, 32'hFFFF_FFFF));
        quiet = 1'b1;
        gen_random(160);

        wait_drained();
        repeat (10) @(posedge clk);
        if (exp_q.size() != 0)
            report_mismatch("expectations left over", 64'(exp_q.size()), 64'd0);
        if (err_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
